// ----- design/bnof_pkg.sv -----
`default_nettype none

package bnof_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W        = 16;
	localparam int DIFF_W         = COORD_W + 1;
	localparam int HXY_W          = 10;
	localparam int HZ_W           = 12;
	localparam int MINNB_W        = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = HZ_W;
	localparam int PIDX_W         = 6;

	localparam logic [HXY_W-1:0]   HXY_RST   = HXY_W'(20);
	localparam logic [HZ_W-1:0]    HZ_RST    = HZ_W'(1000);
	localparam logic [MINNB_W-1:0] MINNB_RST = MINNB_W'(5);

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_XY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_NB  = CFG_IDX_W'(2);

	// x in the lowest bits, as on the input bus
	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} count_ctl_t;

endpackage

`default_nettype wire

// ----- design/bnof_cell.sv -----
`default_nettype none

module bnof_cell
	import bnof_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire point_t shift_pt,
	input  wire logic   shift_pres,
	input  wire logic   load,
	input  wire point_t load_pt,
	input  wire logic   kill,
	input  wire logic   clear_all,
	output      point_t pt,
	output      logic   pres
);

	point_t pt_q;
	logic   pres_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= 1'b0;
		end else if (clear_all || kill) begin
			pres_q <= 1'b0;
		end else if (load) begin
			pres_q <= 1'b1;
		end else if (shift) begin
			pres_q <= shift_pres;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pt_q <= load_pt;
		end else if (shift) begin
			pt_q <= shift_pt;
		end
	end

	assign pt   = pt_q;
	assign pres = pres_q;

endmodule

`default_nettype wire

// ----- design/bnof_count.sv -----
`default_nettype none

module bnof_count
	import bnof_pkg::*;
#(
	parameter int CntW = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire count_ctl_t       ctl,
	input  wire point_t           head,
	input  wire logic             head_pres,
	input  wire point_t           cand,
	input  wire logic [HXY_W-1:0] half_xy,
	input  wire logic [HZ_W-1:0]  half_z,
	output      logic [CntW-1:0]  cnt
);

	function automatic logic in_range(logic signed [DIFF_W-1:0] d, logic [HZ_W-1:0] h);
		logic signed [DIFF_W-1:0] hs;
		hs = signed'({{(DIFF_W-HZ_W){1'b0}}, h});
		return (d <= hs) && (d >= -hs);
	endfunction

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic                     pres_s1;
	logic                     valid_s1;
	logic [CntW-1:0]          cnt_q;
	logic                     hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= ctl.sample;
			if (ctl.clear) begin
				cnt_q <= '0;
			end else if (valid_s1 && hit) begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {head.x[COORD_W-1], head.x} - {cand.x[COORD_W-1], cand.x};
		dy_s1   <= {head.y[COORD_W-1], head.y} - {cand.y[COORD_W-1], cand.y};
		dz_s1   <= {head.z[COORD_W-1], head.z} - {cand.z[COORD_W-1], cand.z};
		pres_s1 <= head_pres;
	end

	assign hit = pres_s1
		&& in_range(dx_s1, {{(HZ_W-HXY_W){1'b0}}, half_xy})
		&& in_range(dy_s1, {{(HZ_W-HXY_W){1'b0}}, half_xy})
		&& in_range(dz_s1, half_z);

	assign cnt = cnt_q;

endmodule

`default_nettype wire

// ----- design/box_neighbor_outlier_filter.sv -----
// loading: one point item per cycle, s_tready high whenever no set is being filtered
// filtering: points circulate in a ring of MaxPoints cells; every verdict takes one
// full turn of the ring, then the DRAIN and VERDICT states; VERDICT holds while a
// result waits unsent; a set of N points gives N verdicts, the first turn only
// fetching the first candidate; result waits in an output register
// reset: asynchronous, active low; empties the store and restores register defaults
`default_nettype none

module box_neighbor_outlier_filter
	import bnof_pkg::*;
#(
	parameter int MaxPoints = MAX_POINTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [47:0]           s_tdata,  // pos_x, pos_y, pos_z
	input  wire logic                  s_tlast,  // end_of_set
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [7:0]            m_tdata,  // point_index, keep, zero pad
	output      logic                  m_tlast,  // last_verdict
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_DRAIN,
		ST_VERDICT
	} state_t;

	state_t             state_q;
	logic [IdxW-1:0]    pass_cnt_q;
	logic [CntW-1:0]    pt_count_q;
	logic [IdxW-1:0]    cur_idx_q;
	logic [IdxW-1:0]    next_idx_q;
	logic               judging_q;
	logic [HXY_W-1:0]   hw_xy_q;
	logic [HZ_W-1:0]    hh_z_q;
	logic [MINNB_W-1:0] min_nb_q;
	logic               m_tvalid_q;
	point_t             cur_cand_q;
	point_t             next_cand_q;
	logic [IdxW-1:0]    out_idx_q;
	logic               out_keep_q;
	logic               out_last_q;

	point_t          cell_pt   [MaxPoints];
	logic            cell_pres [MaxPoints];
	point_t          in_pt;
	logic            accept_in;
	logic            room;
	logic [IdxW-1:0] load_idx;
	logic            out_free;
	logic            verdict_go;
	logic            done;
	logic            keep;
	logic            kill_en;
	logic [CntW-1:0] cnt;
	count_ctl_t      ctl;

	assign in_pt      = s_tdata;
	assign s_tready   = (state_q == ST_IDLE);
	assign accept_in  = s_tvalid && s_tready;
	assign room       = pt_count_q < CntW'(MaxPoints);
	assign load_idx   = pt_count_q[IdxW-1:0];
	assign out_free   = !m_tvalid_q || m_tready;
	assign verdict_go = (state_q == ST_VERDICT) && (!judging_q || out_free);
	assign done       = verdict_go && judging_q && (cur_idx_q == '0);
	assign keep       = MINNB_W'(cnt) >= min_nb_q;
	assign kill_en    = verdict_go && judging_q && !keep;

	assign ctl.sample = (state_q == ST_PASS);
	assign ctl.clear  = (accept_in && s_tlast) || (verdict_go && !done);

	for (genvar k = 0; k < MaxPoints; k++) begin : g_cell
		localparam int Nxt = (k + 1) % MaxPoints;
		bnof_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (state_q == ST_PASS),
			.shift_pt  (cell_pt[Nxt]),
			.shift_pres(cell_pres[Nxt]),
			.load      (accept_in && room && (load_idx == IdxW'(k))),
			.load_pt   (in_pt),
			.kill      (kill_en && (cur_idx_q == IdxW'(k))),
			.clear_all (done),
			.pt        (cell_pt[k]),
			.pres      (cell_pres[k])
		);
	end

	bnof_count #(
		.CntW(CntW)
	) u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.head     (cell_pt[0]),
		.head_pres(cell_pres[0]),
		.cand     (cur_cand_q),
		.half_xy  (hw_xy_q),
		.half_z   (hh_z_q),
		.cnt      (cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_cnt_q <= '0;
			pt_count_q <= '0;
			cur_idx_q  <= '0;
			next_idx_q <= '0;
			judging_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (verdict_go && judging_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						if (room) begin
							pt_count_q <= pt_count_q + CntW'(1);
						end
						if (s_tlast) begin
							next_idx_q <= room ? load_idx : IdxW'(MaxPoints - 1);
							judging_q  <= 1'b0;
							pass_cnt_q <= '0;
							state_q    <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					if (pass_cnt_q == IdxW'(MaxPoints - 1)) begin
						pass_cnt_q <= '0;
						state_q    <= ST_DRAIN;
					end else begin
						pass_cnt_q <= pass_cnt_q + IdxW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_VERDICT;
				end
				ST_VERDICT: begin
					if (done) begin
						pt_count_q <= '0;
						judging_q  <= 1'b0;
						state_q    <= ST_IDLE;
					end else if (verdict_go) begin
						cur_idx_q  <= next_idx_q;
						next_idx_q <= next_idx_q - IdxW'(1);
						judging_q  <= 1'b1;
						pass_cnt_q <= '0;
						state_q    <= ST_PASS;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_xy_q  <= HXY_RST;
			hh_z_q   <= HZ_RST;
			min_nb_q <= MINNB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_XY: hw_xy_q  <= cfg_data[HXY_W-1:0];
				CFG_HALF_Z:  hh_z_q   <= cfg_data[HZ_W-1:0];
				CFG_MIN_NB:  min_nb_q <= cfg_data[MINNB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PASS) && (pass_cnt_q == next_idx_q)) begin
			next_cand_q <= cell_pt[0];
		end
		if (verdict_go) begin
			cur_cand_q <= next_cand_q;
		end
		if (verdict_go && judging_q) begin
			out_idx_q  <= cur_idx_q;
			out_keep_q <= keep;
			out_last_q <= (cur_idx_q == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_keep_q, PIDX_W'(out_idx_q)};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- design/bnof_checker.sv -----
`default_nettype none

module bnof_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed under stall");

	// end of set stops loading while the set is filtered
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("item taken right after end of set");

	// final verdict is for index 0 and only that one
	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[5:0] == 6'd0)
		else $error("final verdict not for index 0");

	a_zero_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5:0] == 6'd0 |-> m_tlast)
		else $error("index 0 verdict without last mark");

endmodule

bind box_neighbor_outlier_filter bnof_checker u_bnof_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import bnof_pkg::*;

	localparam int NPTS           = MAX_POINTS_DEF;
	localparam int VERDICT_CYCLES = NPTS + 2;
	localparam int RANDOM_POINTS  = 410;
	localparam int HOLD_CYCLES    = 2000;

	typedef struct {
		logic [PIDX_W-1:0] index;
		logic              keep;
		logic              last;
	} verdict_t;

	class verdict_board;
		point_t           store [NPTS];
		bit               gone [NPTS];
		int               count;
		logic [HXY_W-1:0]   half_xy;
		logic [HZ_W-1:0]    half_z;
		logic [MINNB_W-1:0] min_nb;
		verdict_t         awaited [$];
		int               errors, verdicts, kept, sets, points, dropped, writes;

		function new();
			count = 0;
			half_xy = HXY_RST;
			half_z = HZ_RST;
			min_nb = MINNB_RST;
			errors = 0; verdicts = 0; kept = 0;
			sets = 0; points = 0; dropped = 0; writes = 0;
			foreach (gone[j]) gone[j] = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			writes++;
			case (idx)
			CFG_HALF_XY: half_xy = val[HXY_W-1:0];
			CFG_HALF_Z:  half_z = val[HZ_W-1:0];
			CFG_MIN_NB:  min_nb = val[MINNB_W-1:0];
			default: ;
			endcase
		endfunction

		function bit close(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b,
				int half);
			int d;
			d = int'(a) - int'(b);
			if (d < 0) d = -d;
			return d <= half;
		endfunction

		// loads a point; the end of a set judges the whole set, highest index first
		function void note_point(point_t p, bit eos);
			int tally;
			verdict_t v;
			points++;
			if (count < NPTS) begin
				store[count] = p;
				gone[count] = 1'b0;
				count++;
			end else begin
				dropped++;
			end
			if (!eos) return;
			sets++;
			for (int i = count - 1; i >= 0; i--) begin
				tally = 0;
				for (int j = 0; j < count; j++) begin
					if (!gone[j] &&
						close(store[j].x, store[i].x, int'(half_xy)) &&
						close(store[j].y, store[i].y, int'(half_xy)) &&
						close(store[j].z, store[i].z, int'(half_z)))
						tally++;
				end
				v.index = i[PIDX_W-1:0];
				v.keep = (tally >= int'(min_nb));
				v.last = (i == 0);
				if (!v.keep) gone[i] = 1'b1;
				awaited = {awaited, v};
			end
			foreach (gone[j]) gone[j] = 1'b0;
			count = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100) $display("mismatch: %s", msg);
		endtask

		task check_verdict(logic [7:0] data, logic last);
			verdict_t v;
			if (awaited.size() == 0) begin
				report($sformatf("verdict for point %0d with none awaited",
					data[PIDX_W-1:0]));
				return;
			end
			v = awaited.pop_front();
			verdicts++;
			if (v.keep) kept++;
			if (data[PIDX_W-1:0] !== v.index)
				report($sformatf("point_index %0d, awaited %0d", data[PIDX_W-1:0], v.index));
			if (data[PIDX_W] !== v.keep)
				report($sformatf("keep %b for point %0d, awaited %b", data[PIDX_W],
					v.index, v.keep));
			if (last !== v.last)
				report($sformatf("last_verdict %b for point %0d, awaited %b", last,
					v.index, v.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;  // pos_x, pos_y, pos_z
	logic                  s_tlast;  // end_of_set
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;  // point_index, keep, zero pad
	logic                  m_tlast;  // last_verdict
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	verdict_board board;
	bit tx_steady, rx_steady, hold_ask;
	int hold_left;

	box_neighbor_outlier_filter #(.MaxPoints(NPTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic point_t pt(int x, int y, int z);
		point_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.z = COORD_W'(z);
		return p;
	endfunction

	function automatic point_t random_point();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic point_t extreme_point();
		int picks [4];
		picks = '{-32768, 32767, 0, -1};
		return pt(picks[$urandom_range(0, 3)], picks[$urandom_range(0, 3)],
			picks[$urandom_range(0, 3)]);
	endfunction

	function automatic point_t scatter(point_t c, int sxy, int sz);
		point_t p;
		p.x = COORD_W'(int'(c.x) + int'($urandom_range(0, 2 * sxy)) - sxy);
		p.y = COORD_W'(int'(c.y) + int'($urandom_range(0, 2 * sxy)) - sxy);
		p.z = COORD_W'(int'(c.z) + int'($urandom_range(0, 2 * sz)) - sz);
		return p;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!rx_steady) stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_verdict(m_tdata, m_tlast);
	end

	task send_point(point_t p, bit eos);
		int unsigned gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
		board.note_point(p, eos);
		@(negedge clk);
	endtask

	task send_set(int n);
		point_t c0, c1, p;
		int sxy, sz, r;
		c0 = random_point();
		c1 = random_point();
		sxy = int'(board.half_xy) + int'(board.half_xy) / 2 + 1;
		sz = int'(board.half_z) + int'(board.half_z) / 2 + 1;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 12) p = random_point();
			else if (r < 20) p = extreme_point();
			else p = scatter(r < 60 ? c0 : c1, sxy, sz);
			send_point(p, k == n - 1);
		end
	endtask

	// wait for every verdict, then give the block time to return to loading
	task settle();
		s_tvalid <= 1'b0;
		while (board.awaited.size() > 0) @(negedge clk);
		repeat (2 * VERDICT_CYCLES) @(negedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		board.set_reg(idx, val);
	endtask

	task set_config(int hxy, int hz, int mnb);
		write_reg(CFG_HALF_XY, CFG_DATA_W'(hxy));
		write_reg(CFG_HALF_Z, CFG_DATA_W'(hz));
		write_reg(CFG_MIN_NB, CFG_DATA_W'(mnb));
	endtask

	task random_config();
		int hxy, hz, mnb;
		case ($urandom_range(0, 3))
		0: hxy = 0;
		1: hxy = 1023;
		2: hxy = int'($urandom_range(0, 1023));
		default: hxy = int'($urandom_range(1, 60));
		endcase
		case ($urandom_range(0, 3))
		0: hz = 0;
		1: hz = 4095;
		2: hz = int'($urandom_range(0, 4095));
		default: hz = int'($urandom_range(1, 200));
		endcase
		case ($urandom_range(0, 4))
		0: mnb = 0;
		1: mnb = 64;
		2: mnb = int'($urandom_range(0, 64));
		default: mnb = int'($urandom_range(1, 5));
		endcase
		set_config(hxy, hz, mnb);
	endtask

	initial begin
		int sent, setno, n;
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_ask = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: lone point, then two points at opposite corners
		send_point(pt(-32768, 32767, 0), 1'b1);
		send_point(pt(32767, -32768, 32767), 1'b0);
		send_point(pt(-32768, 32767, -32768), 1'b1);
		// widest box with a zero minimum keeps everything
		settle();
		set_config(1023, 4095, 0);
		send_point(pt(32767, 32767, 32767), 1'b0);
		send_point(pt(-32768, -32768, -32768), 1'b0);
		send_point(pt(0, 0, 0), 1'b1);
		// minimum above the set size removes everything
		settle();
		set_config(1023, 4095, 64);
		send_point(pt(100, 100, 100), 1'b0);
		send_point(pt(100, 100, 100), 1'b1);
		// zero-size box: only exact duplicates count
		settle();
		set_config(0, 0, 2);
		send_point(pt(-1, -1, -1), 1'b0);
		send_point(pt(-1, -1, -1), 1'b0);
		send_point(pt(-1, -1, 0), 1'b1);
		// inclusive box edges and one past them
		settle();
		set_config(5, 7, 2);
		send_point(pt(0, 0, 0), 1'b0);
		send_point(pt(5, -5, -7), 1'b0);
		send_point(pt(-6, 0, 0), 1'b0);
		send_point(pt(0, 0, 8), 1'b1);
		// removal of a later point takes an earlier one with it
		settle();
		set_config(10, 4095, 3);
		send_point(pt(0, 0, 0), 1'b0);
		send_point(pt(10, 0, 0), 1'b0);
		send_point(pt(20, 0, 0), 1'b1);

		sent = 0;
		setno = 0;
		while (sent < RANDOM_POINTS) begin
			if (setno % 4 == 0 || $urandom_range(0, 3) == 0) begin
				settle();
				random_config();
			end
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if (setno == 3) n = NPTS;
			else if (setno == 8) n = NPTS + 2;
			else if ($urandom_range(0, 19) == 0) n = $urandom_range(30, NPTS);
			else n = $urandom_range(1, 12);
			if (setno == 5) begin
				// receiver stops while a set is filtered and the next one waits at the input
				hold_ask = 1'b1;
				send_set(3);
				sent += 3;
				n = 4;
			end
			send_set(n);
			sent += n;
			setno++;
		end
		settle();

		$display("run covered %0d sets of %0d points (%0d past a full store),",
			board.sets, board.points, board.dropped);
		$display("%0d verdicts, %0d kept, %0d register writes, one hold-off of %0d cycles",
			board.verdicts, board.kept, board.writes, HOLD_CYCLES);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
